@@ rtl/bcd_multiplexed_digit_driver_unit_defines.svh @@
// ----------------------------------------------------------------------------
// BCD digit driver assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during rst_n low.
// ----------------------------------------------------------------------------
`ifndef BCD_MULTIPLEXED_DIGIT_DRIVER_UNIT_DEFINES_SVH
`define BCD_MULTIPLEXED_DIGIT_DRIVER_UNIT_DEFINES_SVH

// Condition holds at every clock edge
`define BMDD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define BMDD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define BMDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bmdd_pkg.sv @@
// ----------------------------------------------------------------------------
// BCD digit driver package
// Widths, the load bundle between conversion and emitter, and the
// double-dabble step and range-limit helpers.
// ----------------------------------------------------------------------------
package bmdd_pkg;

    localparam int BIN_W      = 16;                  // binary input width
    localparam int NIB_W      = 4;                   // one BCD digit
    localparam int BCD_DIGITS = 5;                   // digits of a 16-bit value
    localparam int BCD_W      = NIB_W * BCD_DIGITS;
    localparam int WORK_W     = BCD_W + BIN_W;       // double-dabble work word
    localparam int NDIG_W     = 4;                   // digit count
    localparam int CFG_W      = 3;                   // digits_in_use register
    localparam int SEL_W      = 4;                   // digit select lines
    localparam int OUT_DATA_W = SEL_W + NIB_W;       // output tdata width
    localparam int DABBLE_STEPS = 8;                 // shift steps per stage

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

    // Conversion result handed to the digit emitter
    typedef struct packed {
        logic [BCD_W-1:0]  bcd;    // digit k at bits 4k+3..4k, k=0 least significant
        logic [NDIG_W-1:0] ndig;   // effective digit count
        logic              ovf;    // value does not fit
    } bmdd_load_t;

    // Eight double-dabble steps: adjust each BCD nibble, then shift left one bit
    function automatic logic [WORK_W-1:0] dabble8(input logic [WORK_W-1:0] s);
        logic [WORK_W-1:0] w;
        w = s;
        for (int i = 0; i < DABBLE_STEPS; i++)
        begin
            for (int k = 0; k < BCD_DIGITS; k++)
            begin
                if (w[BIN_W + NIB_W*k +: NIB_W] >= 4'd5)
                begin
                    w[BIN_W + NIB_W*k +: NIB_W] = w[BIN_W + NIB_W*k +: NIB_W] + 4'd3;
                end
            end
            w = {w[WORK_W-2:0], 1'b0};
        end
        return w;
    endfunction

    // Smallest value that does not fit in d decimal digits (d of 1 to 5; any other d gives 100000)
    function automatic logic [BIN_W:0] pow10_limit(input logic [NDIG_W-1:0] d);
        logic [BIN_W:0] lim;
        unique case (d)
            4'd1:    lim = 17'd10;
            4'd2:    lim = 17'd100;
            4'd3:    lim = 17'd1000;
            4'd4:    lim = 17'd10000;
            default: lim = 17'd100000;
        endcase
        return lim;
    endfunction

endpackage

@@ rtl/bmdd_digit_emitter.sv @@
// ----------------------------------------------------------------------------
// BCD digit emitter
// Output register that sends one digit per transaction, most significant
// first, or a single overflow result.
// ----------------------------------------------------------------------------
`include "bcd_multiplexed_digit_driver_unit_defines.svh"

module bmdd_digit_emitter #(
    parameter int MAX_DIGITS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ld_valid,
    output logic                            ld_ready,
    input  bmdd_pkg::bmdd_load_t            ld,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmdd_pkg::OUT_DATA_W-1:0] m_tdata,   // [3:0] digit_select, [7:4] bcd_digit
    output logic                            m_tlast,   // last
    output logic                            m_tuser    // overflow
);
    import bmdd_pkg::*;

    localparam int DIG_W = NIB_W * MAX_DIGITS;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic             out_valid_reg, out_valid_next;
    logic [SEL_W-1:0] sel_reg,       sel_next;
    logic [DIG_W-1:0] dig_reg,       dig_next;
    logic [CNT_W-1:0] rem_reg,       rem_next;
    logic             ovf_reg,       ovf_next;

    logic             last_w;
    logic             out_done;
    logic             ld_fire;
    logic [DIG_W-1:0] dig_ext;
    logic [7:0]       shamt;

    // Place converted digits into the emitter width
    for (genvar k = 0; k < MAX_DIGITS; k++)
    begin : g_ext
        if (k < BCD_DIGITS)
        begin : g_used
            assign dig_ext[NIB_W*k +: NIB_W] = ld.bcd[NIB_W*k +: NIB_W];
        end
        else
        begin : g_zero
            assign dig_ext[NIB_W*k +: NIB_W] = '0;
        end
    end

    // Handshake
    assign last_w   = (rem_reg == CNT_W'(1));
    assign out_done = out_valid_reg && m_tready;
    assign ld_ready = !out_valid_reg || (m_tready && last_w);
    assign ld_fire  = ld_valid && ld_ready;

    // Shift so the most significant shown digit sits in the top nibble
    assign shamt = 8'(NIB_W * MAX_DIGITS) - 8'({ld.ndig, 2'b00});

    // Next state
    always_comb
    begin
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        dig_next       = dig_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        if (out_done)
        begin
            if (last_w)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                sel_next = {sel_reg[SEL_W-2:0], 1'b0};
                dig_next = {dig_reg[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
                rem_next = rem_reg - CNT_W'(1);
            end
        end
        if (ld_fire)
        begin
            out_valid_next = 1'b1;
            if (ld.ovf)
            begin
                sel_next = '0;
                dig_next = '0;
                rem_next = CNT_W'(1);
                ovf_next = 1'b1;
            end
            else
            begin
                sel_next = SEL_W'(1);
                dig_next = dig_ext << shamt;
                rem_next = CNT_W'(ld.ndig);
                ovf_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        dig_reg <= dig_next;
        ovf_reg <= ovf_next;
    end

    // Outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {dig_reg[DIG_W-1 -: NIB_W], sel_reg};
    assign m_tlast  = last_w;
    assign m_tuser  = ovf_reg;

    // Checks
    `BMDD_ASSERT_IMPLY(a_ovf_single, out_valid_reg && ovf_reg, last_w && (sel_reg == '0) && (dig_reg[DIG_W-1 -: NIB_W] == '0), "overflow result not a lone blank result")
    `BMDD_ASSERT_IMPLY(a_digit_range, out_valid_reg && !ovf_reg, (dig_reg[DIG_W-1 -: NIB_W] <= 4'd9) && $onehot0(sel_reg), "bad BCD digit or select")
    `BMDD_ASSERT_IMPLY(a_rem_range, out_valid_reg, (rem_reg != '0) && (int'(rem_reg) <= MAX_DIGITS), "remaining count out of range")
    `BMDD_ASSERT_NEXT(a_step, out_done && !last_w, out_valid_reg && (rem_reg == $past(rem_reg) - CNT_W'(1)), "digit sequence did not advance")

endmodule

@@ rtl/bcd_multiplexed_digit_driver_unit.sv @@
// ----------------------------------------------------------------------------
// BCD multiplexed digit driver
// Converts a binary value to BCD and sends one digit per transaction,
// most significant first, with a one-hot digit select; overflow gives one
// error result.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    tdata[15:0] value
//   m_*       out   m_tvalid/m_tready    tdata[3:0] select, [7:4] BCD; tlast; tuser overflow
//   cfg_*     in    cfg_wr_en            cfg_wr_data digits_in_use
//
// Input transactions are taken every cycle while the pipeline has room.
// From input to the first result a value passes the input register, the
// s2 stage register and the output register (two conversion stages of 8
// double-dabble steps lie between them). Each item gives one result per digit of
// the effective count (digits_in_use clamped to 1..MAX_DIGITS, 1 on overflow): the
// emitter sends one digit per cycle while m_tready is high, which sets the sustained rate.
// Reset clears valid flags and loads digits_in_use with 3; no clearing pass.
// Output stalls back up through the stages to s_tready.
// ----------------------------------------------------------------------------
module bcd_multiplexed_digit_driver_unit #(
    parameter int MAX_DIGITS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [bmdd_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bmdd_pkg::BIN_W-1:0]      s_tdata,   // [15:0] value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmdd_pkg::OUT_DATA_W-1:0] m_tdata,   // [3:0] digit_select, [7:4] bcd_digit
    output logic                            m_tlast,   // last
    output logic                            m_tuser    // overflow
);
    import bmdd_pkg::*;

    logic [CFG_W-1:0]  digits_in_use_reg;
    logic [NDIG_W-1:0] eff_digits;
    logic              in_ovf;

    logic              s1_valid_reg;
    logic [WORK_W-1:0] s1_work_reg;
    logic [NDIG_W-1:0] s1_ndig_reg;
    logic              s1_ovf_reg;
    logic              s1_ready;

    logic              s2_valid_reg;
    logic [WORK_W-1:0] s2_work_reg;
    logic [NDIG_W-1:0] s2_ndig_reg;
    logic              s2_ovf_reg;
    logic              s2_ready;

    logic [WORK_W-1:0] conv_work;
    bmdd_load_t        ld_info;
    logic              ld_ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_in_use_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            digits_in_use_reg <= cfg_wr_data;
        end
    end

    // Clamp digit count to 1..MAX_DIGITS
    always_comb
    begin
        priority if (digits_in_use_reg == '0)
        begin
            eff_digits = NDIG_W'(1);
        end
        else if (int'(digits_in_use_reg) > MAX_DIGITS)
        begin
            eff_digits = NDIG_W'(MAX_DIGITS);
        end
        else
        begin
            eff_digits = NDIG_W'(digits_in_use_reg);
        end
    end

    assign in_ovf = ({1'b0, s_tdata} >= pow10_limit(eff_digits));

    // Stage readiness
    assign s2_ready = !s2_valid_reg || ld_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Input register and first half of the conversion
    always_ff @(posedge clk)
    begin
        if (s1_ready && s_tvalid)
        begin
            s1_work_reg <= {{BCD_W{1'b0}}, s_tdata};
            s1_ndig_reg <= eff_digits;
            s1_ovf_reg  <= in_ovf;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_work_reg <= dabble8(s1_work_reg);
            s2_ndig_reg <= s1_ndig_reg;
            s2_ovf_reg  <= s1_ovf_reg;
        end
    end

    // Second half of the conversion feeds the emitter
    assign conv_work    = dabble8(s2_work_reg);
    assign ld_info.bcd  = conv_work[WORK_W-1 -: BCD_W];
    assign ld_info.ndig = s2_ndig_reg;
    assign ld_info.ovf  = s2_ovf_reg;

    bmdd_digit_emitter #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld_valid (s2_valid_reg),
        .ld_ready (ld_ready),
        .ld       (ld_info),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
